// File: rtl/fscq_pkg.sv
package fscq_pkg;

  localparam int COLOR_W  = 8;
  localparam int COUNT_W  = 24;
  localparam int POS_W    = 8;
  localparam int LENGTH_W = 6;
  localparam int ENTRY_W  = COLOR_W + COUNT_W;

  typedef enum logic [1:0] {
    REQ_APPEND = 2'd0,
    REQ_INSERT = 2'd1,
    REQ_REMOVE = 2'd2,
    REQ_READ   = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  // logical index source for the shared address adder
  typedef enum logic [1:0] {
    IDX_ZERO,
    IDX_POS,
    IDX_K,
    IDX_FILL
  } idx_sel_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_RD_WAIT,
    S_INS_RD,
    S_INS_CHK,
    S_RESP
  } state_e;

  typedef struct packed {
    logic [COLOR_W-1:0] color;
    logic [COUNT_W-1:0] count;
  } entry_t;

  typedef struct packed {
    logic     capture;
    logic     res_set;
    status_e  res_status;
    idx_sel_e idx_sel;
    logic     append;
    logic     rd_take;
    logic     pop;
    logic     ins_init;
    logic     ins_step;
    logic     ins_finish;
    logic     load_out;
  } cmd_t;

  typedef struct packed {
    req_e req;
    logic full;
    logic empty;
    logic pos_oob;
    logic k_end;
  } stat_t;

endpackage

// File: rtl/fscq_ram.sv
module fscq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/fscq_datapath.sv
module fscq_datapath import fscq_pkg::*; #(
  parameter int CAPACITY = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cmd_t                cmd_i,
  output stat_t               stat_o,
  input  logic [1:0]          req_type_i,
  input  logic [COLOR_W-1:0]  color_in_i,
  input  logic [COUNT_W-1:0]  count_in_i,
  input  logic [POS_W-1:0]    position_i,
  output logic [1:0]          status_o,
  output logic [COLOR_W-1:0]  color_out_o,
  output logic [COUNT_W-1:0]  count_out_o,
  output logic [LENGTH_W-1:0] length_o,
  output logic                is_empty_o
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = (CW > POS_W) ? CW : POS_W;

  // captured request
  req_e               req_q;
  logic [COLOR_W-1:0] color_q;
  logic [COUNT_W-1:0] count_q;
  logic [POS_W-1:0]   pos_q;

  // queue bookkeeping
  logic [AW-1:0] head_q, head_d;
  logic [CW-1:0] fill_q, fill_d;
  logic [CW-1:0] k_q, k_d;
  logic          placing_q, placing_d;
  entry_t        carry_q;

  // result and output registers
  status_e             res_status_q;
  logic [COLOR_W-1:0]  res_color_q;
  logic [COUNT_W-1:0]  res_count_q;
  logic [1:0]          status_q;
  logic [COLOR_W-1:0]  color_out_q;
  logic [COUNT_W-1:0]  count_out_q;
  logic [LENGTH_W-1:0] length_q;
  logic                is_empty_q;

  logic [CW-1:0]  lidx;
  logic [AW:0]    addr_sum;
  logic [AW:0]    addr_wrap;
  logic [AW-1:0]  ram_addr;
  logic           ram_we;
  entry_t         ram_wdata;
  entry_t         rd_entry;
  logic [ENTRY_W-1:0] ram_rdata;
  entry_t         new_entry;
  logic           greater;

  // logical index to ring address
  always_comb begin
    unique case (cmd_i.idx_sel)
      IDX_ZERO: lidx = '0;
      IDX_POS:  lidx = CW'(pos_q);
      IDX_K:    lidx = k_q;
      IDX_FILL: lidx = fill_q;
      default:  lidx = '0;
    endcase
  end

  assign addr_sum  = {1'b0, head_q} + (AW+1)'(lidx);
  assign addr_wrap = (addr_sum >= (AW+1)'(CAPACITY)) ? addr_sum - (AW+1)'(CAPACITY)
                                                      : addr_sum;
  assign ram_addr  = addr_wrap[AW-1:0];

  assign rd_entry  = ram_rdata;
  assign new_entry = '{color: color_q, count: count_q};
  assign greater   = rd_entry.count > count_q;

  // first larger entry takes the new one, every later entry moves up one slot
  assign ram_we    = cmd_i.append | cmd_i.ins_finish |
                     (cmd_i.ins_step & (placing_q | greater));
  assign ram_wdata = (!cmd_i.append && placing_q) ? carry_q : new_entry;

  fscq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    fill_d = fill_q;
    if (cmd_i.append || cmd_i.ins_finish) begin
      fill_d = fill_q + CW'(1);
    end else if (cmd_i.pop) begin
      fill_d = fill_q - CW'(1);
    end
  end

  always_comb begin
    head_d = head_q;
    if (cmd_i.pop) begin
      head_d = (head_q == AW'(CAPACITY - 1)) ? '0 : head_q + AW'(1);
    end
  end

  always_comb begin
    k_d       = k_q;
    placing_d = placing_q;
    if (cmd_i.ins_init) begin
      k_d       = '0;
      placing_d = 1'b0;
    end else if (cmd_i.ins_step) begin
      k_d       = k_q + CW'(1);
      placing_d = placing_q | greater;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q    <= '0;
      fill_q    <= '0;
      k_q       <= '0;
      placing_q <= 1'b0;
    end else begin
      head_q    <= head_d;
      fill_q    <= fill_d;
      k_q       <= k_d;
      placing_q <= placing_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q   <= req_e'(req_type_i);
      color_q <= color_in_i;
      count_q <= count_in_i;
      pos_q   <= position_i;
    end
    if (cmd_i.ins_step && (placing_q || greater)) begin
      carry_q <= rd_entry;
    end
    if (cmd_i.res_set) begin
      res_status_q <= cmd_i.res_status;
      res_color_q  <= '0;
      res_count_q  <= '0;
    end else if (cmd_i.rd_take) begin
      res_color_q <= rd_entry.color;
      res_count_q <= rd_entry.count;
    end
    if (cmd_i.load_out) begin
      status_q    <= res_status_q;
      color_out_q <= res_color_q;
      count_out_q <= res_count_q;
      length_q    <= LENGTH_W'(fill_q);
      is_empty_q  <= (fill_q == '0);
    end
  end

  assign stat_o.req     = req_q;
  assign stat_o.full    = (fill_q == CW'(CAPACITY));
  assign stat_o.empty   = (fill_q == '0);
  assign stat_o.pos_oob = PW'(pos_q) >= PW'(fill_q);
  assign stat_o.k_end   = (k_q == fill_q);

  assign status_o    = status_q;
  assign color_out_o = color_out_q;
  assign count_out_o = count_out_q;
  assign length_o    = length_q;
  assign is_empty_o  = is_empty_q;

  a_fill_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CW'(CAPACITY))
    else $error("fill level beyond capacity");

  a_grow_not_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.append || cmd_i.ins_finish) |-> (fill_q != CW'(CAPACITY)))
    else $error("entry added to a full queue");

  a_pop_not_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pop |-> (fill_q != '0))
    else $error("head removed from an empty queue");

  a_scan_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.ins_step |-> (k_q < fill_q))
    else $error("insert scan ran past the tail");

endmodule

// File: rtl/fscq_ctrl.sv
module fscq_ctrl import fscq_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || out_ready_i;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_EXEC;
      end
      S_EXEC: begin
        unique case (stat_i.req)
          REQ_APPEND: state_d = S_RESP;
          REQ_INSERT: state_d = stat_i.full ? S_RESP : S_INS_RD;
          REQ_REMOVE: state_d = stat_i.empty ? S_RESP : S_RD_WAIT;
          REQ_READ:   state_d = (stat_i.empty || stat_i.pos_oob) ? S_RESP : S_RD_WAIT;
          default:    state_d = S_RESP;
        endcase
      end
      S_RD_WAIT: state_d = S_RESP;
      S_INS_RD:  state_d = stat_i.k_end ? S_RESP : S_INS_CHK;
      S_INS_CHK: state_d = S_INS_RD;
      S_RESP: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd_o      = '0;
    cmd_o.res_status = ST_OK;
    cmd_o.idx_sel    = IDX_ZERO;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      S_EXEC: begin
        cmd_o.res_set = 1'b1;
        unique case (stat_i.req)
          REQ_APPEND: begin
            if (stat_i.full) begin
              cmd_o.res_status = ST_FULL;
            end else begin
              cmd_o.append  = 1'b1;
              cmd_o.idx_sel = IDX_FILL;
            end
          end
          REQ_INSERT: begin
            if (stat_i.full) cmd_o.res_status = ST_FULL;
            else             cmd_o.ins_init   = 1'b1;
          end
          REQ_REMOVE: begin
            if (stat_i.empty) cmd_o.res_status = ST_EMPTY;
          end
          REQ_READ: begin
            if (stat_i.empty)        cmd_o.res_status = ST_EMPTY;
            else if (stat_i.pos_oob) cmd_o.res_status = ST_RANGE;
            else                     cmd_o.idx_sel    = IDX_POS;
          end
          default: cmd_o.res_status = ST_OK;
        endcase
      end
      S_RD_WAIT: begin
        cmd_o.rd_take = 1'b1;
        cmd_o.pop     = (stat_i.req == REQ_REMOVE);
      end
      S_INS_RD: begin
        cmd_o.idx_sel    = IDX_K;
        cmd_o.ins_finish = stat_i.k_end;
      end
      S_INS_CHK: begin
        cmd_o.idx_sel  = IDX_K;
        cmd_o.ins_step = 1'b1;
      end
      S_RESP: begin
        cmd_o.load_out = out_free;
      end
      default: in_ready_o = 1'b0;
    endcase
  end

  assign out_valid_d = cmd_o.load_out || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  a_load_when_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> (!out_valid_q || out_ready_i))
    else $error("result overwritten before it was taken");

endmodule

// File: rtl/frequency_sorted_color_queue_unit.sv
// frequency sorted color queue
//
// in channel (in_valid_i / in_ready_o) takes one request item: append at
// tail, insert by frequency (after equal keys), remove head or read at a
// position from the head. out channel (out_valid_o / out_ready_i) returns
// one result item per request: status, color and count of the entry
// concerned (zero otherwise), length after the request and an empty flag.
// entries live in a ring buffer in one single-port ram with registered
// read; head pointer and fill level are flip-flops.
// insert scans the queued entries in turn, each with a ram read step
// (S_INS_RD) and then a compare/shift step (S_INS_CHK).
// one request is worked at a time: in_ready_o is high only in idle, the
// cycle after the result is loaded; a new item may be accepted while the
// previous result still waits.
// reset clears fill level, head pointer and control; ram contents are not
// cleared, as no entry is read before it is written.
// a stalled receiver holds the result; a finished request waits until the
// output register frees up, and the input stays blocked meanwhile.
module frequency_sorted_color_queue_unit import fscq_pkg::*; #(
  parameter int CAPACITY = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          req_type_i,
  input  logic [COLOR_W-1:0]  color_in_i,
  input  logic [COUNT_W-1:0]  count_in_i,
  input  logic [POS_W-1:0]    position_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [1:0]          status_o,
  output logic [COLOR_W-1:0]  color_out_o,
  output logic [COUNT_W-1:0]  count_out_o,
  output logic [LENGTH_W-1:0] length_o,
  output logic                is_empty_o
);

  // command and status between sequencer and datapath
  cmd_t  cmd;
  stat_t stat;

  fscq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // ring buffer, insert scan and result registers
  fscq_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .req_type_i  (req_type_i),
    .color_in_i  (color_in_i),
    .count_in_i  (count_in_i),
    .position_i  (position_i),
    .status_o    (status_o),
    .color_out_o (color_out_o),
    .count_out_o (count_out_o),
    .length_o    (length_o),
    .is_empty_o  (is_empty_o)
  );

endmodule
